>>> src/ptp_pkg.sv
// ============================================================================
// ptp_pkg
// Shared widths, latencies and helpers for the point-to-plane projection pipe.
// ============================================================================
`default_nettype none

package ptp_pkg;

    // operand digit for the partial-product multipliers
    localparam int DIG_W = 32;

    // field widths
    localparam int W_COORD  = 32;
    localparam int W_DIFF   = W_COORD + 1;       // difference of two coordinates
    localparam int W_CROSS  = 2 * W_DIFF;        // component of an edge cross product
    localparam int W_NN     = 2 * W_CROSS;       // squared normal length, unsigned
    localparam int W_DOT    = W_DIFF + W_CROSS + 1;   // (P - C) . N
    localparam int W_WDOT   = W_NN + 1;          // ((v - u) x (p - u)) . N
    localparam int W_FRAC   = 16;
    localparam int W_WNUM   = W_WDOT + W_FRAC;
    localparam int W_PNUM   = W_CROSS + W_DOT;   // N_i * d
    localparam int W_WEIGHT = 24;
    localparam int W_TOL    = 18;
    localparam int W_PQ     = 42;                // projection offset, clamped to +-2^40

    // quotient bits resolved by the dividers
    localparam int QW_PROJ = 41;
    localparam int QW_WT   = 24;

    localparam logic [63:0] PQ_LIM     = 64'd1 << 40;
    localparam logic [63:0] WT_LIM_POS = 64'd8388607;
    localparam logic [63:0] WT_LIM_NEG = 64'd8388608;

    // stage counts
    localparam int MUL_LAT      = 4;
    localparam int CROSS_LAT    = MUL_LAT + 1;
    localparam int DOT_LAT      = MUL_LAT + 1;
    localparam int DIV_LAT_PROJ = QW_PROJ + 3;
    localparam int DIV_LAT_WT   = QW_WT + 3;

    function automatic logic signed [W_DIFF-1:0] f_diff(
        input logic signed [W_COORD-1:0] x,
        input logic signed [W_COORD-1:0] y
    );
        return W_DIFF'(x) - W_DIFF'(y);
    endfunction

endpackage

`default_nettype wire

>>> src/ptp_mul.sv
// ============================================================================
// ptp_mul
// Signed multiplier, sign-magnitude, built from 32x32-bit partial products.
// ============================================================================
`default_nettype none

module ptp_mul
    import ptp_pkg::*;
#(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic signed [WA-1:0]  i_a,
    input  wire logic signed [WB-1:0]  i_b,
    output logic signed [WA+WB-1:0]    o_p
);

    localparam int DA = (WA + DIG_W - 1) / DIG_W;
    localparam int DB = (WB + DIG_W - 1) / DIG_W;
    localparam int WP = WA + WB;
    localparam int WX = DIG_W * (DA + DB);

    logic [DA*DIG_W-1:0] r_ma;
    logic [DB*DIG_W-1:0] r_mb;
    logic                r_neg1, r_neg2, r_neg3;
    logic [2*DIG_W-1:0]  r_pp [DA][DB];
    logic [WP-1:0]       r_sum, n_sum;
    logic [WP-1:0]       r_p;

    // take magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= (DA*DIG_W)'($unsigned(i_a[WA-1] ? -i_a : i_a));
            r_mb   <= (DB*DIG_W)'($unsigned(i_b[WB-1] ? -i_b : i_b));
            r_neg1 <= i_a[WA-1] ^ i_b[WB-1];
        end
    end

    // partial products
    for (genvar gi = 0; gi < DA; gi++) begin : g_row
        for (genvar gj = 0; gj < DB; gj++) begin : g_col
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pp[gi][gj] <= (2*DIG_W)'(r_ma[gi*DIG_W +: DIG_W]) *
                                    (2*DIG_W)'(r_mb[gj*DIG_W +: DIG_W]);
                end
            end
        end
    end

    always_comb begin
        logic [WX-1:0] acc;
        acc = '0;
        for (int i = 0; i < DA; i++) begin
            for (int j = 0; j < DB; j++) begin
                acc = acc + (WX'(r_pp[i][j]) << (DIG_W * (i + j)));
            end
        end
        n_sum = acc[WP-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg2 <= r_neg1;
            r_sum  <= n_sum;
            r_neg3 <= r_neg2;
            r_p    <= r_neg3 ? -r_sum : r_sum;
        end
    end

    assign o_p = $signed(r_p);

endmodule

`default_nettype wire

>>> src/ptp_cross.sv
// ============================================================================
// ptp_cross
// Cross product of two 3-vectors; operands are coordinate differences.
// ============================================================================
`default_nettype none

module ptp_cross
    import ptp_pkg::*;
#(
    parameter int W = W_DIFF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [2:0][W-1:0]    i_a,
    input  wire logic [2:0][W-1:0]    i_b,
    output logic [2:0][2*W-1:0]       o_c
);

    logic [2:0][2*W-1:0] r_c;

    for (genvar k = 0; k < 3; k++) begin : g_comp
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;
        logic signed [2*W-1:0] w_p1, w_p2;

        ptp_mul #(.WA(W), .WB(W)) u_m1 (
            .i_clk(i_clk), .i_en(i_en),
            .i_a($signed(i_a[K1])), .i_b($signed(i_b[K2])), .o_p(w_p1)
        );
        ptp_mul #(.WA(W), .WB(W)) u_m2 (
            .i_clk(i_clk), .i_en(i_en),
            .i_a($signed(i_a[K2])), .i_b($signed(i_b[K1])), .o_p(w_p2)
        );

        // differences of W-1 bit values keep the result inside 2W bits
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_c[k] <= w_p1 - w_p2;
            end
        end
    end

    assign o_c = r_c;

endmodule

`default_nettype wire

>>> src/ptp_dot.sv
// ============================================================================
// ptp_dot
// Dot product of two 3-vectors with a registered final sum.
// ============================================================================
`default_nettype none

module ptp_dot
    import ptp_pkg::*;
#(
    parameter int WA = W_CROSS,
    parameter int WB = W_CROSS,
    parameter int WO = W_WDOT
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [2:0][WA-1:0]  i_a,
    input  wire logic [2:0][WB-1:0]  i_b,
    output logic signed [WO-1:0]     o_d
);

    localparam int WS = WA + WB + 2;

    logic signed [WA+WB-1:0] w_p [3];
    logic signed [WO-1:0]    r_d;

    for (genvar k = 0; k < 3; k++) begin : g_term
        ptp_mul #(.WA(WA), .WB(WB)) u_mul (
            .i_clk(i_clk), .i_en(i_en),
            .i_a($signed(i_a[k])), .i_b($signed(i_b[k])), .o_p(w_p[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= WO'(WS'(w_p[0]) + WS'(w_p[1]) + WS'(w_p[2]));
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

>>> src/ptp_div.sv
// ============================================================================
// ptp_div
// Pipelined restoring divider: round half away from zero, then clamp.
// One quotient bit per stage, overflow detected up front.
// ============================================================================
`default_nettype none

module ptp_div
    import ptp_pkg::*;
#(
    parameter int          WN      = W_WNUM,
    parameter int          WD      = W_NN,
    parameter int          QW      = QW_WT,
    parameter int          WO      = W_WEIGHT,
    parameter logic [63:0] LIM_POS = WT_LIM_POS,
    parameter logic [63:0] LIM_NEG = WT_LIM_NEG
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [WN-1:0] i_num,
    input  wire logic [WD-1:0]        i_den,
    output logic signed [WO-1:0]      o_q
);

    localparam int WR = ((WN > WD) ? WN : WD) + 2;

    logic [WN-1:0]  w_mag;
    logic [WR-1:0]  r_num;
    logic [WD:0]    r_den;
    logic           r_negp;

    logic [WR-1:0]  r_rem [QW];
    logic [WD:0]    r_dv  [QW];
    logic [QW-1:0]  r_q   [QW+1];
    logic           r_sat [QW+1];
    logic           r_neg [QW+1];
    logic signed [WO-1:0] r_out, n_q;

    assign w_mag = $unsigned(i_num[WN-1] ? -i_num : i_num);

    // numerator 2|n| + d over divisor 2d
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= (WR'(w_mag) << 1) + WR'(i_den);
            r_den  <= {i_den, 1'b0};
            r_negp <= i_num[WN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= r_num;
            r_dv[0]  <= r_den;
            r_q[0]   <= '0;
            r_sat[0] <= (r_num >> QW) >= WR'(r_den);
            r_neg[0] <= r_negp;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_bit
        localparam int B = QW - k;
        logic w_ge;

        assign w_ge = (r_rem[k-1] >> B) >= WR'(r_dv[k-1]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]   <= r_q[k-1] | (w_ge ? (QW'(1) << B) : QW'(0));
                r_sat[k] <= r_sat[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end

        if (k < QW) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dv[k]  <= r_dv[k-1];
                    r_rem[k] <= w_ge ? r_rem[k-1] - (WR'(r_dv[k-1]) << B) : r_rem[k-1];
                end
            end
        end
    end

    // clamp the magnitude, then restore the sign
    always_comb begin
        logic [QW:0]          qm;
        logic [QW:0]          lim;
        logic signed [QW+1:0] sv;
        qm  = r_sat[QW] ? ((QW+1)'(1) << QW) : {1'b0, r_q[QW]};
        lim = r_neg[QW] ? LIM_NEG[QW:0] : LIM_POS[QW:0];
        sv  = $signed({1'b0, ((qm > lim) ? lim : qm)});
        n_q = WO'(r_neg[QW] ? -sv : sv);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_q;
        end
    end

    assign o_q = r_out;

endmodule

`default_nettype wire

>>> src/ptp_dly.sv
// ============================================================================
// ptp_dly
// Enabled delay line that carries side data alongside the arithmetic.
// ============================================================================
`default_nettype none

module ptp_dly
    import ptp_pkg::*;
#(
    parameter int W     = W_COORD,
    parameter int DEPTH = MUL_LAT
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [W-1:0]  i_d,
    output logic [W-1:0]       o_d
);

    logic [W-1:0] r_sr [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_d = r_sr[DEPTH-1];

endmodule

`default_nettype wire

>>> src/point_triangle_projection.sv
// Throughput: one word per cycle unless the output stalls; the projection divider,
// with its 41 quotient-bit stages, sets the depth.
// A stalled output freezes the whole pipe; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits and the tolerance to 0.
// ============================================================================
// point_triangle_projection
// Projects a point onto a triangle's plane and reports barycentric weights,
// plane side, inside test against a programmable tolerance, and degeneracy.
// ============================================================================
`default_nettype none

module point_triangle_projection
    import ptp_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // configuration: bary_tolerance
    input  wire logic          i_cfg_we,
    input  wire logic [17:0]   i_cfg_wdata,
    // input stream
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // point_x, point_y, point_z, corner_a_x/y/z, corner_b_x/y/z, corner_c_x/y/z
    input  wire logic [383:0]  s_axis_tdata,
    // output stream
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // proj_x, proj_y, proj_z, weight_a, weight_b, weight_c
    output logic [167:0]       m_axis_tdata,
    // on_normal_side, inside_res, degenerate
    output logic [2:0]         m_axis_tuser
);

    // Stage map, counted in register stages after the accept edge:
    //   1       coordinate differences
    //   T_X     normal N and the three weight cross products
    //   T_D     |N|^2, d = (P - C) . N, and the three weight dot products
    //   T_ND    N_i * d
    //   T_WQ    rounded weights, waiting for the projection
    //   T_PQ    rounded projection offsets
    //   T_PQ+1  output register
    localparam int T_X   = 1 + CROSS_LAT;
    localparam int T_D   = T_X + DOT_LAT;
    localparam int T_ND  = T_D + MUL_LAT;
    localparam int T_PQ  = T_ND + DIV_LAT_PROJ;
    localparam int T_WQ  = T_D + DIV_LAT_WT;
    localparam int N_STG = T_PQ + 1;

    localparam logic signed [W_PQ:0] V_MAX = (W_PQ+1)'(64'sd2147483647);
    localparam logic signed [W_PQ:0] V_MIN = (W_PQ+1)'(-64'sd2147483648);

    logic                       w_en;
    logic [N_STG-1:0]           r_vld;
    logic signed [W_TOL-1:0]    r_tol;

    // Whole pipe advances together; hold everything while the output waits.
    assign w_en          = m_axis_tready || !r_vld[N_STG-1];
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[N_STG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N_STG-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_we) begin
            r_tol <= $signed(i_cfg_wdata);
        end
    end

    // ---------------------------------------------------------------- stage 1
    // Unpack the word and form every edge and point difference.
    logic signed [W_COORD-1:0] w_p [3], w_a [3], w_b [3], w_c [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_p[i] = $signed(s_axis_tdata[W_COORD*i +: W_COORD]);
            w_a[i] = $signed(s_axis_tdata[W_COORD*(3+i) +: W_COORD]);
            w_b[i] = $signed(s_axis_tdata[W_COORD*(6+i) +: W_COORD]);
            w_c[i] = $signed(s_axis_tdata[W_COORD*(9+i) +: W_COORD]);
        end
    end

    logic [2:0][W_DIFF-1:0]  r_e1, r_e2, r_pc, r_fb, r_eca, r_bma, r_fa;
    logic [3*W_COORD-1:0]    r_p;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i]  <= f_diff(w_c[i], w_b[i]);
                r_e2[i]  <= f_diff(w_a[i], w_b[i]);
                r_pc[i]  <= f_diff(w_p[i], w_c[i]);
                r_fb[i]  <= f_diff(w_p[i], w_b[i]);
                r_eca[i] <= f_diff(w_a[i], w_c[i]);
                r_bma[i] <= f_diff(w_b[i], w_a[i]);
                r_fa[i]  <= f_diff(w_p[i], w_a[i]);
            end
            r_p <= s_axis_tdata[3*W_COORD-1:0];
        end
    end

    // ---------------------------------------------------------------- cross products
    logic [2:0][W_CROSS-1:0] w_n, w_xa, w_xb, w_xc;
    logic [2:0][W_DIFF-1:0]  w_pc_x;

    ptp_cross #(.W(W_DIFF)) u_cross_n (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_e1), .i_b(r_e2), .o_c(w_n)
    );
    ptp_cross #(.W(W_DIFF)) u_cross_a (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_e1), .i_b(r_fb), .o_c(w_xa)
    );
    ptp_cross #(.W(W_DIFF)) u_cross_b (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_eca), .i_b(r_pc), .o_c(w_xb)
    );
    ptp_cross #(.W(W_DIFF)) u_cross_c (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_bma), .i_b(r_fa), .o_c(w_xc)
    );

    ptp_dly #(.W(3*W_DIFF), .DEPTH(T_X-1)) u_dly_pc (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_pc), .o_d(w_pc_x)
    );

    // ---------------------------------------------------------------- dot products
    logic signed [W_WDOT-1:0] w_nn_s, w_wd_a, w_wd_b, w_wd_c;
    logic signed [W_DOT-1:0]  w_d;
    logic [W_NN-1:0]          w_nn;
    logic [2:0][W_CROSS-1:0]  w_n_d;

    ptp_dot #(.WA(W_CROSS), .WB(W_CROSS), .WO(W_WDOT)) u_dot_nn (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_n), .i_b(w_n), .o_d(w_nn_s)
    );
    ptp_dot #(.WA(W_DIFF), .WB(W_CROSS), .WO(W_DOT)) u_dot_d (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_pc_x), .i_b(w_n), .o_d(w_d)
    );
    ptp_dot #(.WA(W_CROSS), .WB(W_CROSS), .WO(W_WDOT)) u_dot_a (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_xa), .i_b(w_n), .o_d(w_wd_a)
    );
    ptp_dot #(.WA(W_CROSS), .WB(W_CROSS), .WO(W_WDOT)) u_dot_b (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_xb), .i_b(w_n), .o_d(w_wd_b)
    );
    ptp_dot #(.WA(W_CROSS), .WB(W_CROSS), .WO(W_WDOT)) u_dot_c (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_xc), .i_b(w_n), .o_d(w_wd_c)
    );

    // sum of squares is never negative
    assign w_nn = w_nn_s[W_NN-1:0];

    ptp_dly #(.W(3*W_CROSS), .DEPTH(T_D-T_X)) u_dly_n (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_n), .o_d(w_n_d)
    );

    // ---------------------------------------------------------------- weights
    logic signed [W_WEIGHT-1:0] w_wq [3];
    logic signed [W_WDOT-1:0]   w_wdot [3];

    assign w_wdot[0] = w_wd_a;
    assign w_wdot[1] = w_wd_b;
    assign w_wdot[2] = w_wd_c;

    for (genvar k = 0; k < 3; k++) begin : g_wt
        ptp_div #(
            .WN(W_WNUM), .WD(W_NN), .QW(QW_WT), .WO(W_WEIGHT),
            .LIM_POS(WT_LIM_POS), .LIM_NEG(WT_LIM_NEG)
        ) u_div (
            .i_clk(i_clk), .i_en(w_en),
            .i_num({w_wdot[k], {W_FRAC{1'b0}}}), .i_den(w_nn), .o_q(w_wq[k])
        );
    end

    logic [3*W_WEIGHT-1:0] w_wt_d;

    ptp_dly #(.W(3*W_WEIGHT), .DEPTH(T_PQ-T_WQ)) u_dly_wt (
        .i_clk(i_clk), .i_en(w_en),
        .i_d({w_wq[2], w_wq[1], w_wq[0]}), .o_d(w_wt_d)
    );

    // ---------------------------------------------------------------- projection
    logic [W_NN-1:0]        w_nn_nd;
    logic signed [W_PQ-1:0] w_pq [3];
    logic [1:0]             w_flag_d;
    logic [3*W_COORD-1:0]   w_p_d;

    ptp_dly #(.W(W_NN), .DEPTH(T_ND-T_D)) u_dly_nn (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_nn), .o_d(w_nn_nd)
    );

    for (genvar k = 0; k < 3; k++) begin : g_proj
        logic signed [W_PNUM-1:0] w_nd;

        ptp_mul #(.WA(W_CROSS), .WB(W_DOT)) u_mul (
            .i_clk(i_clk), .i_en(w_en),
            .i_a($signed(w_n_d[k])), .i_b(w_d), .o_p(w_nd)
        );

        ptp_div #(
            .WN(W_PNUM), .WD(W_NN), .QW(QW_PROJ), .WO(W_PQ),
            .LIM_POS(PQ_LIM), .LIM_NEG(PQ_LIM)
        ) u_div (
            .i_clk(i_clk), .i_en(w_en),
            .i_num(w_nd), .i_den(w_nn_nd), .o_q(w_pq[k])
        );
    end

    // carry the plane side and degeneracy to the end
    ptp_dly #(.W(2), .DEPTH(T_PQ-T_D)) u_dly_flag (
        .i_clk(i_clk), .i_en(w_en),
        .i_d({(w_nn == '0), w_d[W_DOT-1]}), .o_d(w_flag_d)
    );

    ptp_dly #(.W(3*W_COORD), .DEPTH(T_PQ-1)) u_dly_p (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_p), .o_d(w_p_d)
    );

    // ---------------------------------------------------------------- output stage
    logic [167:0] r_tdata, n_tdata;
    logic [2:0]   r_tuser, n_tuser;

    always_comb begin
        logic signed [W_PQ:0]       v;
        logic signed [W_WEIGHT-1:0] wt;
        logic                       all_in;
        logic                       degen;
        degen   = w_flag_d[1];
        all_in  = 1'b1;
        n_tdata = '0;
        for (int i = 0; i < 3; i++) begin
            v = (W_PQ+1)'($signed(w_p_d[W_COORD*i +: W_COORD])) - (W_PQ+1)'(w_pq[i]);
            if (v > V_MAX) begin
                v = V_MAX;
            end else if (v < V_MIN) begin
                v = V_MIN;
            end
            n_tdata[W_COORD*i +: W_COORD] = v[W_COORD-1:0];
            wt = $signed(w_wt_d[W_WEIGHT*i +: W_WEIGHT]);
            n_tdata[3*W_COORD + W_WEIGHT*i +: W_WEIGHT] = wt;
            if (wt < W_WEIGHT'(r_tol)) begin
                all_in = 1'b0;
            end
        end
        n_tuser = {1'b0, all_in, !w_flag_d[0]};
        // drop every result field for a zero-area triangle
        if (degen) begin
            n_tdata = '0;
            n_tuser = 3'b100;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tdata <= n_tdata;
            r_tuser <= n_tuser;
        end
    end

    assign m_axis_tdata = r_tdata;
    assign m_axis_tuser = r_tuser;

`ifndef SYNTH
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tdata == '0 && m_axis_tuser[1:0] == 2'b00))
        else $error("degenerate result carries nonzero fields");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_inside_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
            ($signed(m_axis_tdata[119:96]) >= W_WEIGHT'(r_tol) &&
             $signed(m_axis_tdata[143:120]) >= W_WEIGHT'(r_tol) &&
             $signed(m_axis_tdata[167:144]) >= W_WEIGHT'(r_tol)))
        else $error("inside flag set with a weight below tolerance");
`endif

endmodule

`default_nettype wire
